[src/mfab_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MPI fragment blender package
// Shared widths, codes, command/status bundles and helper functions.
// ----------------------------------------------------------------------------
package mfab_pkg;

	// default geometry
	localparam int unsigned ATLAS_WIDTH_DEF  = 256;
	localparam int unsigned ATLAS_HEIGHT_DEF = 256;
	localparam int unsigned ATLAS_COUNT_DEF  = 2;
	localparam int unsigned VIEW_WIDTH_DEF   = 256;
	localparam int unsigned VIEW_HEIGHT_DEF  = 256;

	// atlas coordinates go up to 4096 entries per axis
	localparam int unsigned COORD_W = 12;

	// stream and config port widths
	localparam int unsigned S_DATA_W   = 168;
	localparam int unsigned S_USER_W   = 3;
	localparam int unsigned M_DATA_W   = 80;
	localparam int unsigned M_USER_W   = 1;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// fixed point constants
	localparam logic [16:0] ONE_Q16       = 17'h10000;
	localparam logic [17:0] SUM_MAX       = 18'h3FFFF;
	localparam logic [16:0] MIN_ALPHA_RST = 17'd13107;
	localparam logic [15:0] COL_MAX       = 16'hFFFF;

	// shared divider: dividend, divisor and quotient widths
	localparam int unsigned DVD_W = 52;
	localparam int unsigned DVS_W = 35;
	localparam int unsigned QUO_W = 34;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_BLEND = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_MIN_ALPHA = 2'd0,
		REG_DISP_LOW  = 2'd1,
		REG_DISP_HIGH = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_VRD,
		ST_VCHK,
		ST_TRD,
		ST_TDAT,
		ST_TACC,
		ST_BCHK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL,
		ST_WB,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;
		logic       atlas_wr;
		logic       view_clr;
		logic       view_rd;
		logic       view_wr;
		logic       tex_rd;
		logic       tex_wa;
		logic       tex_acc;
		logic       acc_clr;
		logic       res_clr;
		logic       div_start;
		logic       div_store;
		logic       mul;
		logic       out_load;
		logic [1:0] lane;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    load_ok;
		logic    pix_ok;
		logic    sel_ok;
		logic    pix_full;
		logic    read_empty;
		logic    ow_zero;
		logic    depth_ok;
		logic    div_busy;
		logic    div_done;
		logic    out_free;
	} status_t;

	typedef struct packed {
		logic [15:0] pid;
		logic [16:0] alpha;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} atl_ent_t;

	typedef struct packed {
		logic        dep_vld;
		logic [31:0] dep;
		logic [16:0] alpha;
		logic [17:0] sum_r;
		logic [17:0] sum_g;
		logic [17:0] sum_b;
	} view_ent_t;

	typedef struct packed {
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		logic [7:0]         frac;
	} axis_t;

	// 2x2 footprint along one axis, edge clamped
	function automatic axis_t gather(logic [16:0] t, logic [COORD_W:0] size);
		logic [8:0]         base;
		logic [COORD_W-1:0] lim;
		logic [COORD_W-1:0] lo;
		axis_t              r;
		base   = (t >= 17'd128) ? 9'((t - 17'd128) >> 8) : 9'd0;
		lim    = COORD_W'(size - 1'b1);
		lo     = (COORD_W'(base) > lim) ? lim : COORD_W'(base);
		r.lo   = lo;
		r.hi   = (lo >= lim) ? lim : lo + 1'b1;
		r.frac = {~t[7], t[6:0]};
		return r;
	endfunction

	// bilinear weight of texel j (0: x0y1, 1: x1y1, 2: x1y0, 3: x0y0)
	function automatic logic [16:0] tex_weight(logic [1:0] j, logic [7:0] fx, logic [7:0] fy);
		logic [8:0] wx;
		logic [8:0] wy;
		wx = (j == 2'd1 || j == 2'd2) ? {1'b0, fx} : 9'd256 - {1'b0, fx};
		wy = (j == 2'd0 || j == 2'd1) ? {1'b0, fy} : 9'd256 - {1'b0, fy};
		return 17'(wx) * 17'(wy);
	endfunction

endpackage
`default_nettype wire

[src/mfab_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MPI fragment blender divider
// Restoring divider, one quotient bit per cycle, QUO_W quotient bits per divide.
// ----------------------------------------------------------------------------
module mfab_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [mfab_pkg::DVD_W-1:0] dividend,
	input  wire logic [mfab_pkg::DVS_W-1:0] divisor,
	output logic                            busy,
	output logic                            done,
	output logic [mfab_pkg::QUO_W-1:0]      quotient
);
	localparam int unsigned DSH_W = mfab_pkg::DVS_W + mfab_pkg::QUO_W - 1;
	localparam int unsigned CNT_W = $clog2(mfab_pkg::QUO_W + 1);

	logic [mfab_pkg::DVD_W-1:0] rem_q;
	logic [DSH_W-1:0]           dsh_q;
	logic [mfab_pkg::QUO_W-1:0] quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [DSH_W-1:0]           rem_ext;
	logic                       ge;

	// trial subtract against the shifted divisor
	assign rem_ext = DSH_W'(rem_q);
	assign ge      = (rem_ext >= dsh_q);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(mfab_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder, divisor and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DSH_W'(divisor) << (mfab_pkg::QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= mfab_pkg::DVD_W'(rem_ext - dsh_q);
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[mfab_pkg::QUO_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[src/mfab_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MPI fragment blender datapath
// Atlas and viewport memories, accumulators, divider, config and output reg.
// ----------------------------------------------------------------------------
module mfab_dp #(
	parameter int unsigned ATLAS_WIDTH  = mfab_pkg::ATLAS_WIDTH_DEF,
	parameter int unsigned ATLAS_HEIGHT = mfab_pkg::ATLAS_HEIGHT_DEF,
	parameter int unsigned ATLAS_COUNT  = mfab_pkg::ATLAS_COUNT_DEF,
	parameter int unsigned VIEW_WIDTH   = mfab_pkg::VIEW_WIDTH_DEF,
	parameter int unsigned VIEW_HEIGHT  = mfab_pkg::VIEW_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [mfab_pkg::S_DATA_W-1:0]   s_data,
	input  wire logic [mfab_pkg::S_USER_W-1:0]   s_user,
	input  wire mfab_pkg::cmd_t                  cmd,
	output mfab_pkg::status_t                    st,
	input  wire logic                            cfg_we,
	input  wire logic [mfab_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mfab_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                                 m_valid,
	input  wire logic                            m_ready,
	output logic [mfab_pkg::M_DATA_W-1:0]        m_data,
	output logic [mfab_pkg::M_USER_W-1:0]        m_user
);
	localparam int unsigned ADEPTH = ATLAS_COUNT * ATLAS_WIDTH * ATLAS_HEIGHT;
	localparam int unsigned AAW    = $clog2(ADEPTH);
	localparam int unsigned VDEPTH = VIEW_WIDTH * VIEW_HEIGHT;
	localparam int unsigned VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
	localparam int unsigned PLANE  = ATLAS_WIDTH * ATLAS_HEIGHT;

	// config registers
	logic [16:0] min_alpha_q;
	logic [31:0] disp_low_q;
	logic [31:0] disp_high_q;

	// captured item
	mfab_pkg::opcode_t op_q;
	logic              sel_q;
	logic [7:0]        x_q;
	logic [7:0]        y_q;
	logic [16:0]       u_q;
	logic [16:0]       v_q;
	logic [31:0]       fdep_q;
	logic [15:0]       pid_q;
	logic [15:0]       red_q;
	logic [15:0]       green_q;
	logic [15:0]       blue_q;
	logic [16:0]       ain_q;

	// memories and their read registers
	mfab_pkg::atl_ent_t  atlas_mem [ADEPTH];
	mfab_pkg::view_ent_t view_mem [VDEPTH];
	mfab_pkg::atl_ent_t  atl_rd_q;
	mfab_pkg::view_ent_t view_rd_q;

	// accumulators
	logic [33:0]                wa_q;
	logic                       match_q;
	logic [mfab_pkg::DVS_W-1:0] osum_q;
	logic [mfab_pkg::DVD_W-1:0] cs_q [3];
	logic [15:0]                c_q [3];
	logic [32:0]                prod_q [3];
	logic [16:0]                ow_q;

	// read result
	logic [15:0] res_col_q [3];
	logic [31:0] res_disp_q;
	logic        res_valid_q;

	// output register
	logic                          m_valid_q;
	logic [mfab_pkg::M_DATA_W-1:0] m_data_q;
	logic [mfab_pkg::M_USER_W-1:0] m_user_q;

	// combinational helpers
	mfab_pkg::axis_t            gx;
	mfab_pkg::axis_t            gy;
	logic [mfab_pkg::COORD_W-1:0] trow;
	logic [mfab_pkg::COORD_W-1:0] tcol;
	logic [AAW-1:0]             ld_addr;
	logic [AAW-1:0]             tx_addr;
	logic [VAW-1:0]             pix_addr;
	logic [16:0]                alpha_sat;
	logic [16:0]                tw;
	logic [15:0]                atl_col [3];
	logic [17:0]                vsum [3];
	logic [16:0]                room;
	logic [18:0]                ow_raw;
	logic [16:0]                ow_c;
	logic [mfab_pkg::DVD_W-1:0] dvd;
	logic [mfab_pkg::DVS_W-1:0] dvs;
	logic [mfab_pkg::QUO_W-1:0] quo;
	logic                       div_busy;
	logic                       div_done;
	logic [mfab_pkg::QUO_W-1:0] dclamp;
	logic [18:0]                fsum [3];
	logic [17:0]                fsat [3];
	logic [31:0]                new_dep;
	mfab_pkg::view_ent_t        view_new;

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_alpha_q <= mfab_pkg::MIN_ALPHA_RST;
			disp_low_q  <= '0;
			disp_high_q <= '1;
		end else if (cfg_we) begin
			unique case (mfab_pkg::cfg_reg_t'(cfg_index))
				mfab_pkg::REG_MIN_ALPHA: min_alpha_q <= cfg_wdata[16:0];
				mfab_pkg::REG_DISP_LOW:  disp_low_q  <= cfg_wdata;
				mfab_pkg::REG_DISP_HIGH: disp_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// opcode of the item in hand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= mfab_pkg::OP_LOAD;
		end else if (cmd.capture) begin
			op_q <= mfab_pkg::opcode_t'(s_user[1:0]);
		end
	end

	// item fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sel_q   <= s_user[2];
			x_q     <= s_data[7:0];
			y_q     <= s_data[15:8];
			u_q     <= s_data[32:16];
			v_q     <= s_data[49:33];
			fdep_q  <= s_data[81:50];
			pid_q   <= s_data[97:82];
			red_q   <= s_data[113:98];
			green_q <= s_data[129:114];
			blue_q  <= s_data[145:130];
			ain_q   <= s_data[162:146];
		end
	end

	// addresses
	assign gx   = mfab_pkg::gather(u_q, (mfab_pkg::COORD_W+1)'(ATLAS_WIDTH));
	assign gy   = mfab_pkg::gather(v_q, (mfab_pkg::COORD_W+1)'(ATLAS_HEIGHT));
	assign trow = (cmd.lane == 2'd0 || cmd.lane == 2'd1) ? gy.hi : gy.lo;
	assign tcol = (cmd.lane == 2'd1 || cmd.lane == 2'd2) ? gx.hi : gx.lo;
	assign ld_addr = AAW'(sel_q) * AAW'(PLANE) + AAW'(y_q) * AAW'(ATLAS_WIDTH) + AAW'(x_q);
	assign tx_addr = AAW'(sel_q) * AAW'(PLANE) + AAW'(trow) * AAW'(ATLAS_WIDTH) + AAW'(tcol);
	assign pix_addr = VAW'(y_q) * VAW'(VIEW_WIDTH) + VAW'(x_q);
	assign alpha_sat = (ain_q > mfab_pkg::ONE_Q16) ? mfab_pkg::ONE_Q16 : ain_q;

	// atlas memory
	always_ff @(posedge clk) begin
		if (cmd.atlas_wr) begin
			atlas_mem[ld_addr] <= '{pid: pid_q, alpha: alpha_sat, red: red_q,
				green: green_q, blue: blue_q};
		end
		if (cmd.tex_rd) begin
			atl_rd_q <= atlas_mem[tx_addr];
		end
	end

	// viewport memory
	always_ff @(posedge clk) begin
		if (cmd.view_clr) begin
			view_mem[pix_addr] <= '0;
		end else if (cmd.view_wr) begin
			view_mem[pix_addr] <= view_new;
		end
		if (cmd.view_rd) begin
			view_rd_q <= view_mem[pix_addr];
		end
	end

	// texel fields, pixel sums
	assign atl_col[0] = atl_rd_q.red;
	assign atl_col[1] = atl_rd_q.green;
	assign atl_col[2] = atl_rd_q.blue;
	assign vsum[0]    = view_rd_q.sum_r;
	assign vsum[1]    = view_rd_q.sum_g;
	assign vsum[2]    = view_rd_q.sum_b;
	assign tw = mfab_pkg::tex_weight(cmd.lane, gx.frac, gy.frac);

	// texel weighting and accumulation
	always_ff @(posedge clk) begin
		if (cmd.tex_wa) begin
			wa_q    <= 34'(tw) * 34'(atl_rd_q.alpha);
			match_q <= (atl_rd_q.pid == pid_q);
		end
		if (cmd.acc_clr) begin
			osum_q <= '0;
			for (int k = 0; k < 3; k++) begin
				cs_q[k] <= '0;
			end
		end else if (cmd.tex_acc && match_q) begin
			osum_q <= osum_q + mfab_pkg::DVS_W'(wa_q);
			for (int k = 0; k < 3; k++) begin
				cs_q[k] <= cs_q[k] + mfab_pkg::DVD_W'(50'(wa_q) * 50'(atl_col[k]));
			end
		end
	end

	// fragment weight limited to the room left in the pixel
	assign room   = mfab_pkg::ONE_Q16 - view_rd_q.alpha;
	assign ow_raw = 19'(osum_q >> 16);
	assign ow_c   = (ow_raw > 19'(room)) ? room : 17'(ow_raw);

	// divider operands
	always_comb begin
		if (op_q == mfab_pkg::OP_BLEND) begin
			dvs = osum_q;
			unique case (cmd.lane)
				2'd0:    dvd = cs_q[0];
				2'd1:    dvd = cs_q[1];
				default: dvd = cs_q[2];
			endcase
		end else if (cmd.lane == 2'd3) begin
			dvd = mfab_pkg::DVD_W'(1) << 32;
			dvs = mfab_pkg::DVS_W'(view_rd_q.dep);
		end else begin
			dvs = mfab_pkg::DVS_W'(view_rd_q.alpha);
			unique case (cmd.lane)
				2'd0:    dvd = mfab_pkg::DVD_W'({vsum[0], 16'h0});
				2'd1:    dvd = mfab_pkg::DVD_W'({vsum[1], 16'h0});
				default: dvd = mfab_pkg::DVD_W'({vsum[2], 16'h0});
			endcase
		end
	end

	mfab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	// disparity clamp, high bound wins
	always_comb begin
		dclamp = quo;
		if (dclamp < mfab_pkg::QUO_W'(disp_low_q)) begin
			dclamp = mfab_pkg::QUO_W'(disp_low_q);
		end
		if (dclamp > mfab_pkg::QUO_W'(disp_high_q)) begin
			dclamp = mfab_pkg::QUO_W'(disp_high_q);
		end
	end

	// quotient capture
	always_ff @(posedge clk) begin
		if (cmd.res_clr) begin
			res_disp_q  <= '0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				res_col_q[k] <= '0;
			end
		end else if (cmd.div_store) begin
			if (op_q == mfab_pkg::OP_BLEND) begin
				unique case (cmd.lane)
					2'd0:    c_q[0] <= quo[15:0];
					2'd1:    c_q[1] <= quo[15:0];
					default: c_q[2] <= quo[15:0];
				endcase
			end else if (cmd.lane == 2'd3) begin
				res_disp_q  <= 32'(dclamp);
				res_valid_q <= 1'b1;
			end else begin
				unique case (cmd.lane)
					2'd0:    res_col_q[0] <= (quo > mfab_pkg::QUO_W'(mfab_pkg::COL_MAX)) ?
						mfab_pkg::COL_MAX : quo[15:0];
					2'd1:    res_col_q[1] <= (quo > mfab_pkg::QUO_W'(mfab_pkg::COL_MAX)) ?
						mfab_pkg::COL_MAX : quo[15:0];
					default: res_col_q[2] <= (quo > mfab_pkg::QUO_W'(mfab_pkg::COL_MAX)) ?
						mfab_pkg::COL_MAX : quo[15:0];
				endcase
			end
		end
	end

	// weight times normalised colour
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			ow_q <= ow_c;
			for (int k = 0; k < 3; k++) begin
				prod_q[k] <= 33'(ow_c) * 33'(c_q[k]);
			end
		end
	end

	// new pixel entry
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fsum[k] = 19'(vsum[k]) + 19'(prod_q[k][32:16]);
			fsat[k] = (fsum[k] > 19'(mfab_pkg::SUM_MAX)) ? mfab_pkg::SUM_MAX : fsum[k][17:0];
		end
		new_dep = (view_rd_q.dep_vld && view_rd_q.dep < fdep_q) ? view_rd_q.dep : fdep_q;
		view_new.dep_vld = 1'b1;
		view_new.dep     = new_dep;
		view_new.alpha   = view_rd_q.alpha + ow_q;
		view_new.sum_r   = fsat[0];
		view_new.sum_g   = fsat[1];
		view_new.sum_b   = fsat[2];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= {res_disp_q, res_col_q[2], res_col_q[1], res_col_q[0]};
			m_user_q <= res_valid_q;
		end
	end

	assign m_valid = m_valid_q;
	assign m_data  = m_data_q;
	assign m_user  = m_user_q;

	// status
	assign st.op         = op_q;
	assign st.load_ok    = (32'(sel_q) < ATLAS_COUNT) && (32'(x_q) < ATLAS_WIDTH) &&
		(32'(y_q) < ATLAS_HEIGHT);
	assign st.pix_ok     = (32'(x_q) < VIEW_WIDTH) && (32'(y_q) < VIEW_HEIGHT);
	assign st.sel_ok     = (32'(sel_q) < ATLAS_COUNT);
	assign st.pix_full   = (view_rd_q.alpha >= mfab_pkg::ONE_Q16);
	assign st.read_empty = (view_rd_q.alpha <= min_alpha_q) || (view_rd_q.alpha == '0);
	assign st.ow_zero    = (ow_c == '0);
	assign st.depth_ok   = view_rd_q.dep_vld && (view_rd_q.dep != '0);
	assign st.div_busy   = div_busy;
	assign st.div_done   = div_done;
	assign st.out_free   = !m_valid_q || m_ready;

endmodule
`default_nettype wire

[src/mfab_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MPI fragment blender controller
// Sequences load, clear, blend and read over the datapath.
// ----------------------------------------------------------------------------
module mfab_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_valid,
	output logic                   s_ready,
	input  wire mfab_pkg::status_t st,
	output mfab_pkg::cmd_t         cmd
);
	mfab_pkg::state_t state_q;
	mfab_pkg::state_t state_d;
	logic [1:0]       lane_q;
	logic [1:0]       lane_d;
	logic             is_read;
	logic             skip_disp;

	assign is_read   = (st.op == mfab_pkg::OP_READ);
	assign skip_disp = is_read && (lane_q == 2'd3) && !st.depth_ok;

	// state and lane registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfab_pkg::ST_IDLE;
			lane_q  <= '0;
		end else begin
			state_q <= state_d;
			lane_q  <= lane_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		lane_d  = lane_q;
		unique case (state_q)
			mfab_pkg::ST_IDLE: begin
				if (s_valid) state_d = mfab_pkg::ST_DISPATCH;
			end
			mfab_pkg::ST_DISPATCH: begin
				unique case (st.op)
					mfab_pkg::OP_LOAD:  state_d = mfab_pkg::ST_IDLE;
					mfab_pkg::OP_CLEAR: state_d = mfab_pkg::ST_IDLE;
					mfab_pkg::OP_BLEND: state_d = (st.pix_ok && st.sel_ok) ?
						mfab_pkg::ST_VRD : mfab_pkg::ST_IDLE;
					default:            state_d = st.pix_ok ?
						mfab_pkg::ST_VRD : mfab_pkg::ST_OUT;
				endcase
			end
			mfab_pkg::ST_VRD: state_d = mfab_pkg::ST_VCHK;
			mfab_pkg::ST_VCHK: begin
				lane_d = '0;
				if (is_read) begin
					state_d = st.read_empty ? mfab_pkg::ST_OUT : mfab_pkg::ST_DIV_GO;
				end else begin
					state_d = st.pix_full ? mfab_pkg::ST_IDLE : mfab_pkg::ST_TRD;
				end
			end
			mfab_pkg::ST_TRD:  state_d = mfab_pkg::ST_TDAT;
			mfab_pkg::ST_TDAT: state_d = mfab_pkg::ST_TACC;
			mfab_pkg::ST_TACC: begin
				if (lane_q == 2'd3) begin
					state_d = mfab_pkg::ST_BCHK;
				end else begin
					lane_d  = lane_q + 1'b1;
					state_d = mfab_pkg::ST_TRD;
				end
			end
			mfab_pkg::ST_BCHK: begin
				lane_d  = '0;
				state_d = st.ow_zero ? mfab_pkg::ST_IDLE : mfab_pkg::ST_DIV_GO;
			end
			mfab_pkg::ST_DIV_GO: begin
				state_d = skip_disp ? mfab_pkg::ST_OUT : mfab_pkg::ST_DIV_WAIT;
			end
			mfab_pkg::ST_DIV_WAIT: begin
				if (st.div_done) begin
					if (!is_read && lane_q == 2'd2) begin
						state_d = mfab_pkg::ST_MUL;
					end else if (is_read && lane_q == 2'd3) begin
						state_d = mfab_pkg::ST_OUT;
					end else begin
						lane_d  = lane_q + 1'b1;
						state_d = mfab_pkg::ST_DIV_GO;
					end
				end
			end
			mfab_pkg::ST_MUL: state_d = mfab_pkg::ST_WB;
			mfab_pkg::ST_WB:  state_d = mfab_pkg::ST_IDLE;
			mfab_pkg::ST_OUT: begin
				if (st.out_free) state_d = mfab_pkg::ST_IDLE;
			end
			default: state_d = mfab_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.lane = lane_q;
		s_ready  = 1'b0;
		unique case (state_q)
			mfab_pkg::ST_IDLE: begin
				s_ready     = 1'b1;
				cmd.capture = s_valid;
			end
			mfab_pkg::ST_DISPATCH: begin
				cmd.atlas_wr = (st.op == mfab_pkg::OP_LOAD) && st.load_ok;
				cmd.view_clr = (st.op == mfab_pkg::OP_CLEAR) && st.pix_ok;
				cmd.res_clr  = is_read;
			end
			mfab_pkg::ST_VRD:      cmd.view_rd   = 1'b1;
			mfab_pkg::ST_VCHK:     cmd.acc_clr   = !is_read;
			mfab_pkg::ST_TRD:      cmd.tex_rd    = 1'b1;
			mfab_pkg::ST_TDAT:     cmd.tex_wa    = 1'b1;
			mfab_pkg::ST_TACC:     cmd.tex_acc   = 1'b1;
			mfab_pkg::ST_BCHK:     ;
			mfab_pkg::ST_DIV_GO:   cmd.div_start = !skip_disp;
			mfab_pkg::ST_DIV_WAIT: cmd.div_store = st.div_done;
			mfab_pkg::ST_MUL:      cmd.mul       = 1'b1;
			mfab_pkg::ST_WB:       cmd.view_wr   = 1'b1;
			mfab_pkg::ST_OUT:      cmd.out_load  = st.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[src/mpi_fragment_alpha_blend.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MPI fragment blender
// Texel atlas load, viewport clear, bilinear patch-masked alpha-saturate
// blend and normalised pixel read-out with clamped disparity.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                         | tuser
//  s_axis   | in  | pos_x pos_y tex_u tex_v frag_depth patch    | opcode atlas_sel
//           |     | red green blue alpha                       |
//  m_axis   | out | out_red out_green out_blue disparity       | disparity_valid
//  cfg      | in  | min_alpha, disparity_low, disparity_high by cfg_index
//
//  One item at a time. Load and clear finish in dispatch; a blend reads the
//  view entry, reads four texels, runs three divides and writes back; a read
//  runs four divides (three with no depth, none when the pixel is empty or
//  off the viewport). Blends and reads share the radix-2 divider.
//  Memories need no clearing; reset sets only control state and config regs.
//  A finished read waits in the output register; a following read stalls
//  until it has been taken.
// ----------------------------------------------------------------------------
module mpi_fragment_alpha_blend #(
	parameter int unsigned ATLAS_WIDTH  = mfab_pkg::ATLAS_WIDTH_DEF,
	parameter int unsigned ATLAS_HEIGHT = mfab_pkg::ATLAS_HEIGHT_DEF,
	parameter int unsigned ATLAS_COUNT  = mfab_pkg::ATLAS_COUNT_DEF,
	parameter int unsigned VIEW_WIDTH   = mfab_pkg::VIEW_WIDTH_DEF,
	parameter int unsigned VIEW_HEIGHT  = mfab_pkg::VIEW_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// pos_x, pos_y, tex_u, tex_v, frag_depth, patch, red, green, blue, alpha
	input  wire logic [mfab_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// opcode, atlas_sel
	input  wire logic [mfab_pkg::S_USER_W-1:0]   s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// out_red, out_green, out_blue, disparity
	output logic [mfab_pkg::M_DATA_W-1:0]        m_axis_tdata,
	// disparity_valid
	output logic [mfab_pkg::M_USER_W-1:0]        m_axis_tuser,
	input  wire logic                            cfg_we,
	input  wire logic [mfab_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mfab_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	mfab_pkg::cmd_t    cmd;
	mfab_pkg::status_t st;

	mfab_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.st      (st),
		.cmd     (cmd)
	);

	mfab_dp #(
		.ATLAS_WIDTH  (ATLAS_WIDTH),
		.ATLAS_HEIGHT (ATLAS_HEIGHT),
		.ATLAS_COUNT  (ATLAS_COUNT),
		.VIEW_WIDTH   (VIEW_WIDTH),
		.VIEW_HEIGHT  (VIEW_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_data    (s_axis_tdata),
		.s_user    (s_axis_tuser),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata),
		.m_user    (m_axis_tuser)
	);

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item accepted while previous one in progress");

	// memory writes and reads never collide
	a_mem_ops: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.atlas_wr, cmd.view_clr, cmd.view_wr, cmd.view_rd}))
		else $error("conflicting memory commands");

	// divider started only when free
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy)
		else $error("divider restarted while busy");

	// invalid disparity reads as zero
	a_disp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[79:48] == 32'h0))
		else $error("disparity nonzero while flagged invalid");

endmodule
`default_nettype wire
